// ----- hw/rtl/bitmap_block_allocator_macros.svh -----
// Assertion macros shared by the bitmap block allocator RTL
`ifndef BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`define BITMAP_BLOCK_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BBA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define BBA_ASSERT(lbl, prop, msg)
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/bba_pkg.sv -----
// Shared constants, codes and control types of the bitmap block allocator
`default_nettype none
package bba_pkg;
	localparam int unsigned NUM_BLOCKS_DEF  = 1024;
	localparam int unsigned BLOCK_BYTES_DEF = 4096;
	localparam int unsigned ROW_BITS = 32;
	localparam int unsigned BIT_W    = 5;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_NULL   = 2'd2;
	localparam logic [1:0] ST_RANGE  = 2'd3;

	typedef struct packed {
		logic cap;
		logic clr_we;
		logic rd_sel_free;
		logic hint_inc;
		logic res_nofree;
		logic alloc_wr;
		logic mul;
		logic add;
		logic fchk1;
		logic fchk2;
		logic div_est;
		logic div_fix;
		logic free_wr;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic hint_full;
		logic row_full;
		logic fail;
	} sts_t;

	function automatic logic [ROW_BITS-1:0] pad_mask(int unsigned valid_bits);
		logic [ROW_BITS-1:0] m;
		m = '0;
		for (int unsigned i = 0; i < ROW_BITS; i++) begin
			m[i] = (i >= valid_bits);
		end
		return m;
	endfunction
endpackage
`default_nettype wire

// ----- hw/rtl/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module bba_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ----- hw/rtl/bba_ctrl.sv -----
// Controller state machine of the bitmap block allocator
`default_nettype none
`include "bitmap_block_allocator_macros.svh"
module bba_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          operation,
	output logic          out_valid,
	input  logic          out_stall,
	output bba_pkg::cmd_t cmd,
	input  bba_pkg::sts_t sts
);
	import bba_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_ACHK  = 4'd2;
	localparam logic [3:0] S_AEVAL = 4'd3;
	localparam logic [3:0] S_AMUL  = 4'd4;
	localparam logic [3:0] S_AADD  = 4'd5;
	localparam logic [3:0] S_FCHK1 = 4'd6;
	localparam logic [3:0] S_FCHK2 = 4'd7;
	localparam logic [3:0] S_FDIV  = 4'd8;
	localparam logic [3:0] S_FRD   = 4'd9;
	localparam logic [3:0] S_FWR   = 4'd10;
	localparam logic [3:0] S_OUT   = 4'd11;
	localparam logic [3:0] S_FFIX  = 4'd12;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLR: begin
				cmd.clr_we = 1'b1;
				if (sts.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.cap = 1'b1;
					state_d = (operation == OP_ALLOC) ? S_ACHK : S_FCHK1;
				end
			end
			S_ACHK: begin
				if (sts.hint_full) begin
					cmd.res_nofree = 1'b1;
					state_d        = S_OUT;
				end else begin
					state_d = S_AEVAL;
				end
			end
			S_AEVAL: begin
				if (sts.row_full) begin
					cmd.hint_inc = 1'b1;
					state_d      = S_ACHK;
				end else begin
					cmd.alloc_wr = 1'b1;
					state_d      = S_AMUL;
				end
			end
			S_AMUL: begin
				cmd.mul = 1'b1;
				state_d = S_AADD;
			end
			S_AADD: begin
				cmd.add = 1'b1;
				state_d = S_OUT;
			end
			S_FCHK1: begin
				cmd.fchk1 = 1'b1;
				state_d   = S_FCHK2;
			end
			S_FCHK2: begin
				cmd.fchk2 = 1'b1;
				state_d   = sts.fail ? S_OUT : S_FDIV;
			end
			S_FDIV: begin
				cmd.div_est = 1'b1;
				state_d     = S_FFIX;
			end
			S_FFIX: begin
				cmd.div_fix = 1'b1;
				state_d     = S_FRD;
			end
			S_FRD: begin
				cmd.rd_sel_free = 1'b1;
				state_d         = S_FWR;
			end
			S_FWR: begin
				cmd.rd_sel_free = 1'b1;
				cmd.free_wr     = 1'b1;
				state_d         = S_OUT;
			end
			S_OUT: begin
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`BBA_ASSERT(a_eval_has_row, (state_q == S_AEVAL) |-> !sts.hint_full, "scan past last row")
	`BBA_ASSERT(a_no_overwrite, cmd.load_out |-> (!out_valid_q || !out_stall), "result lost")
	`BBA_ASSERT_NEXT(a_accept_route, (in_valid && !in_stall), (state_q == S_ACHK || state_q == S_FCHK1), "bad dispatch")
endmodule
`default_nettype wire

// ----- hw/rtl/bba_dp.sv -----
// Datapath of the bitmap block allocator: map RAM, scan hint, range check, divider, address
`default_nettype none
`include "bitmap_block_allocator_macros.svh"
module bba_dp #(
	parameter int unsigned NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
	parameter int unsigned BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  bba_pkg::cmd_t cmd,
	output bba_pkg::sts_t sts,
	input  logic [63:0]   free_address,
	input  logic          cfg_wen,
	input  logic [63:0]   cfg_wdata,
	output logic [63:0]   block_address,
	output logic [1:0]    status
);
	import bba_pkg::*;

	localparam int unsigned ROWS   = (NUM_BLOCKS + ROW_BITS - 1) / ROW_BITS;
	localparam int unsigned ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int unsigned HW     = $clog2(ROWS + 1);
	localparam int unsigned IW     = ROW_AW + BIT_W;
	localparam int unsigned QW     = $clog2(NUM_BLOCKS);
	localparam int unsigned BBW    = $clog2(BLOCK_BYTES + 1);
	localparam int unsigned RW     = QW + BBW;
	localparam int unsigned MW     = QW + 2;
	localparam int unsigned EW     = QW + 1;
	localparam int unsigned PW     = IW + BBW;
	localparam logic [63:0]       LIMIT    = 64'(NUM_BLOCKS) * 64'(BLOCK_BYTES);
	localparam logic [BBW-1:0]    BB_C     = BBW'(BLOCK_BYTES);
	// ceil(2^RW / BLOCK_BYTES): estimate is exact or one too high for offsets below 2^RW
	localparam logic [MW-1:0]     RECIP    =
		MW'(((64'd1 << RW) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES));
	localparam logic [ROW_BITS-1:0] LAST_PAD = pad_mask(NUM_BLOCKS - (ROWS - 1) * ROW_BITS);

	logic [63:0]       base_q;
	logic [HW-1:0]     hint_q;
	logic [ROW_AW-1:0] clr_q;
	logic [63:0]       req_addr_q;
	logic              null_q;
	logic              borrow_q;
	logic [63:0]       diff_q;
	logic [EW-1:0]     est_q;
	logic [QW-1:0]     quo_q;
	logic [IW-1:0]     idx_q;
	logic [PW-1:0]     prod_q;
	logic [63:0]       res_addr_q;
	logic [1:0]        res_status_q;
	logic [63:0]       block_address_q;
	logic [1:0]        status_q;

	logic                ram_we;
	logic [ROW_AW-1:0]   ram_waddr;
	logic [ROW_AW-1:0]   ram_raddr;
	logic [ROW_BITS-1:0] ram_wdata;
	logic [ROW_BITS-1:0] ram_rdata;

	logic [ROW_AW-1:0]   hint_row;
	logic                hint_last;
	logic [ROW_BITS-1:0] masked;
	logic [BIT_W-1:0]    free_pos;
	logic [IW-1:0]       q_idx;
	logic [ROW_AW-1:0]   free_row;
	logic [BIT_W-1:0]    free_bit;
	logic [64:0]         diff_ext;
	logic [RW-1:0]       dvd;
	logic [RW+MW-1:0]    recip_prod;
	logic [RW:0]         back;

	bba_ram #(
		.WIDTH (ROW_BITS),
		.DEPTH (ROWS),
		.AW    (ROW_AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign hint_row   = hint_q[ROW_AW-1:0];
	assign hint_last  = (hint_q == HW'(ROWS - 1));
	assign masked     = ram_rdata | (hint_last ? LAST_PAD : '0);
	assign q_idx      = IW'(quo_q);
	assign free_row   = q_idx[IW-1:BIT_W];
	assign free_bit   = q_idx[BIT_W-1:0];
	assign diff_ext   = {1'b0, req_addr_q} - {1'b0, base_q};
	assign dvd        = diff_q[RW-1:0];
	assign recip_prod = (RW+MW)'(dvd) * (RW+MW)'(RECIP);
	assign back       = (RW+1)'(est_q) * (RW+1)'(BB_C);
	assign ram_raddr  = cmd.rd_sel_free ? free_row : hint_row;

	always_comb begin
		free_pos = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (!masked[i]) free_pos = BIT_W'(i);
		end
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = hint_row;
		ram_wdata = '0;
		if (cmd.clr_we) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
		end else if (cmd.alloc_wr) begin
			ram_we    = 1'b1;
			ram_wdata = ram_rdata | (ROW_BITS'(1) << free_pos);
		end else if (cmd.free_wr) begin
			ram_we    = 1'b1;
			ram_waddr = free_row;
			ram_wdata = ram_rdata & ~(ROW_BITS'(1) << free_bit);
		end
	end

	always_comb begin
		sts.clr_last  = (clr_q == ROW_AW'(ROWS - 1));
		sts.hint_full = (hint_q == HW'(ROWS));
		sts.row_full  = &masked;
		sts.fail      = null_q | borrow_q | (diff_q >= LIMIT);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			hint_q <= '0;
			clr_q  <= '0;
		end else begin
			if (cfg_wen) base_q <= cfg_wdata;
			if (cmd.clr_we) clr_q <= clr_q + ROW_AW'(1);
			if (cmd.hint_inc) begin
				hint_q <= hint_q + HW'(1);
			end else if (cmd.free_wr && (HW'(free_row) < hint_q)) begin
				hint_q <= HW'(free_row);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) req_addr_q <= free_address;
		if (cmd.fchk1) begin
			null_q   <= (req_addr_q == 64'd0);
			borrow_q <= diff_ext[64];
			diff_q   <= diff_ext[63:0];
		end
		if (cmd.fchk2) begin
			if (sts.fail) begin
				res_addr_q   <= '0;
				res_status_q <= null_q ? ST_NULL : ST_RANGE;
			end
		end
		if (cmd.div_est) est_q <= recip_prod[RW+EW-1:RW];
		if (cmd.div_fix) begin
			quo_q <= (back > (RW+1)'(dvd)) ? QW'(est_q - EW'(1)) : QW'(est_q);
		end
		if (cmd.res_nofree) begin
			res_addr_q   <= '0;
			res_status_q <= ST_NOFREE;
		end
		if (cmd.alloc_wr) idx_q <= {hint_row, free_pos};
		if (cmd.mul) prod_q <= PW'(idx_q) * PW'(BB_C);
		if (cmd.add) begin
			res_addr_q   <= base_q + 64'(prod_q);
			res_status_q <= ST_OK;
		end
		if (cmd.free_wr) begin
			res_addr_q   <= '0;
			res_status_q <= ST_OK;
		end
		if (cmd.load_out) begin
			block_address_q <= res_addr_q;
			status_q        <= res_status_q;
		end
	end

	assign block_address = block_address_q;
	assign status        = status_q;

	`BBA_ASSERT(a_hint_bound, hint_q <= HW'(ROWS), "scan hint beyond row count")
	`BBA_ASSERT(a_alloc_in_map, cmd.alloc_wr |-> ({hint_row, free_pos} < NUM_BLOCKS), "pad bit allocated")
	`BBA_ASSERT(a_free_in_map, cmd.free_wr |-> (q_idx < NUM_BLOCKS), "free index out of map")
endmodule
`default_nettype wire

// ----- hw/rtl/bitmap_block_allocator.sv -----
// Top level of the bitmap block allocator: controller plus datapath
`default_nettype none
// First-fit allocator of NUM_BLOCKS blocks of BLOCK_BYTES bytes from the base on cfg_wdata.
// The used-bit map sits in a RAM of 32-bit rows; after reset a clearing pass writes
// ceil(NUM_BLOCKS/32) rows, one per cycle, with in_stall high. One item is worked at a
// time. An allocate runs check, evaluate, multiply and add states, repeating check and
// evaluate for each completely used row the scan steps over past the lowest-row hint (each
// row costs a RAM read and a check); a null or out-of-range free ends after its checks, a
// valid free gets the block index from a reciprocal multiply and a one-step correction.
// A finished result waits in the output register and the next item may be accepted meanwhile.
module bitmap_block_allocator #(
	parameter int unsigned NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEF,
	parameter int unsigned BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        operation,
	input  logic [63:0] free_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] block_address,
	output logic [1:0]  status,
	input  logic        cfg_wen,
	input  logic [63:0] cfg_wdata
);
	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.operation (operation),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.sts       (sts)
	);

	bba_dp #(
		.NUM_BLOCKS  (NUM_BLOCKS),
		.BLOCK_BYTES (BLOCK_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.free_address  (free_address),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.block_address (block_address),
		.status        (status)
	);
endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the bitmap block allocator: directed table plus random phases
module testbench;
	import bba_pkg::*;

	localparam int unsigned NB = NUM_BLOCKS_DEF;
	localparam int unsigned BB = BLOCK_BYTES_DEF;
	localparam logic [63:0] SPAN = 64'(NB) * 64'(BB);
	localparam int unsigned LIMIT = 1000000;
	localparam int unsigned PHASE_ITEMS = 30;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        op;
		logic [63:0] addr;
		logic [10:0] reps;
		logic        typed;
		logic [63:0] t_addr;
		logic [1:0]  t_st;
	} plan_row_t;

	typedef struct packed {
		logic [63:0] addr;
		logic [1:0]  st;
	} alloc_result_t;

	localparam int unsigned PLAN_LEN = 25;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{ROW_CFG,  OP_ALLOC, 64'h0,                   11'd1,    1'b0, 64'h0, ST_OK},
		'{ROW_ITEM, OP_ALLOC, 64'h0,                   11'd1,    1'b1, 64'h0, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'h0,                   11'd1,    1'b1, 64'h0, ST_NULL},
		'{ROW_ITEM, OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 11'd1,    1'b1, 64'h1000, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'h1FFF,                11'd1,    1'b1, 64'h0, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'h1FFF,                11'd1,    1'b1, 64'h0, ST_OK},
		'{ROW_ITEM, OP_ALLOC, 64'h0,                   11'd1,    1'b1, 64'h1000, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'h40_0000,             11'd1,    1'b1, 64'h0, ST_RANGE},
		'{ROW_ITEM, OP_FREE,  64'h3F_FFFF,             11'd1,    1'b1, 64'h0, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'hFFFF_FFFF_FFFF_FFFF, 11'd1,    1'b1, 64'h0, ST_RANGE},
		'{ROW_ITEM, OP_ALLOC, 64'h0,                   11'd1022, 1'b0, 64'h0, ST_OK},
		'{ROW_ITEM, OP_ALLOC, 64'h0,                   11'd1,    1'b1, 64'h0, ST_NOFREE},
		'{ROW_ITEM, OP_FREE,  64'h2ABC,                11'd1,    1'b1, 64'h0, ST_OK},
		'{ROW_ITEM, OP_ALLOC, 64'h0,                   11'd1,    1'b1, 64'h2000, ST_OK},
		'{ROW_ITEM, OP_ALLOC, 64'h5555_AAAA_5555_AAAA, 11'd1,    1'b1, 64'h0, ST_NOFREE},
		'{ROW_CFG,  OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 11'd1,    1'b0, 64'h0, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'hFFFF_FFFF_FFFF_FFFE, 11'd1,    1'b1, 64'h0, ST_RANGE},
		'{ROW_ITEM, OP_FREE,  64'hFFFF_FFFF_FFFF_FFFF, 11'd1,    1'b1, 64'h0, ST_OK},
		'{ROW_ITEM, OP_ALLOC, 64'h0,                   11'd1,    1'b1,
			64'hFFFF_FFFF_FFFF_FFFF, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'h0,                   11'd1,    1'b1, 64'h0, ST_NULL},
		'{ROW_ITEM, OP_FREE,  64'h5,                   11'd1,    1'b1, 64'h0, ST_RANGE},
		'{ROW_CFG,  OP_ALLOC, 64'hFFFF_FFFF_FFFF_F000, 11'd1,    1'b0, 64'h0, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'hFFFF_FFFF_FFFF_F800, 11'd1,    1'b1, 64'h0, ST_OK},
		'{ROW_ITEM, OP_ALLOC, 64'hFFFF_FFFF_FFFF_FFFF, 11'd1,    1'b1,
			64'hFFFF_FFFF_FFFF_F000, ST_OK},
		'{ROW_ITEM, OP_FREE,  64'h1000,                11'd1,    1'b1, 64'h0, ST_RANGE}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        operation = OP_ALLOC;
	logic [63:0] free_address = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [63:0] block_address;
	logic [1:0]  status;
	logic        cfg_wen = 1'b0;
	logic [63:0] cfg_wdata = '0;

	logic [63:0]   base_reg = '0;
	bit            block_used [NB];
	alloc_result_t expected_results [$];
	int unsigned   errors = 0;
	int unsigned   cycle_count = 0;
	bit            calm = 1'b0;

	bitmap_block_allocator #(
		.NUM_BLOCKS(NB),
		.BLOCK_BYTES(BB)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.free_address(free_address),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.block_address(block_address),
		.status(status),
		.cfg_wen(cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever begin
			#5 clk = ~clk;
		end
	end

	initial begin
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL bitmap_block_allocator");
		$finish;
	end

	function automatic alloc_result_t predict_allocator(input logic op, input logic [63:0] a);
		alloc_result_t r;
		logic [63:0]   blk;
		r.addr = '0;
		r.st = ST_NOFREE;
		if (op == OP_ALLOC) begin
			for (int i = 0; i < NB; i++) begin
				if (!block_used[i]) begin
					block_used[i] = 1'b1;
					r.addr = base_reg + 64'(i) * 64'(BB);
					r.st = ST_OK;
					break;
				end
			end
		end else if (a == '0) begin
			r.st = ST_NULL;
		end else if (a < base_reg) begin
			r.st = ST_RANGE;
		end else begin
			blk = (a - base_reg) / 64'(BB);
			if (blk >= 64'(NB)) begin
				r.st = ST_RANGE;
			end else begin
				block_used[blk] = 1'b0;
				r.st = ST_OK;
			end
		end
		return r;
	endfunction

	task automatic offer(input logic op, input logic [63:0] a, input logic typed,
		input logic [63:0] t_addr, input logic [1:0] t_st);
		alloc_result_t r;
		if (!calm && $urandom_range(99) < 30) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(3, 1)) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		free_address <= a;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		r = predict_allocator(op, a);
		if (typed) begin
			r.addr = t_addr;
			r.st = t_st;
		end
		expected_results.push_back(r);
	endtask

	// base changes only with nothing in flight
	task automatic set_base(input logic [63:0] v);
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_wen <= 1'b0;
		base_reg = v;
	endtask

	initial begin : result_check
		alloc_result_t exp_r;
		int unsigned   seen;
		int unsigned   hold_left;
		bit            held;
		seen = 0;
		hold_left = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				seen++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result block_address %h status %0d",
						$time, block_address, status);
					errors++;
				end else begin
					exp_r = expected_results.pop_front();
					if (block_address !== exp_r.addr) begin
						$display("%0t: block_address expected %h actual %h",
							$time, exp_r.addr, block_address);
						errors++;
					end
					if (status !== exp_r.st) begin
						$display("%0t: status expected %0d actual %0d",
							$time, exp_r.st, status);
						errors++;
					end
				end
			end
			// long hold-off while the map fills, to back up the input
			if (!held && seen >= 900) begin
				held = 1'b1;
				hold_left = 500;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 30);
			end
		end
	end

	initial begin : stimulus
		logic [63:0] phase_base [5];
		int unsigned alloc_pct [5];
		int unsigned sel;
		int unsigned idx;
		logic [63:0] a;
		phase_base[0] = 64'h0000_0000_4000_0000;
		phase_base[1] = {$urandom, $urandom};
		phase_base[2] = 64'h0;
		phase_base[3] = 64'hFFFF_FFFF_FFC0_0000;
		phase_base[4] = 64'h0000_0123_4567_89AB;
		alloc_pct[0] = 35;
		alloc_pct[1] = 50;
		alloc_pct[2] = 60;
		alloc_pct[3] = 50;
		alloc_pct[4] = 55;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);

		for (int r = 0; r < PLAN_LEN; r++) begin
			if (PLAN[r].kind == ROW_CFG) begin
				set_base(PLAN[r].addr);
			end else begin
				for (int n = 0; n < PLAN[r].reps; n++) begin
					offer(PLAN[r].op, PLAN[r].addr, PLAN[r].typed, PLAN[r].t_addr, PLAN[r].t_st);
				end
			end
		end

		for (int p = 0; p < 5; p++) begin
			set_base(phase_base[p]);
			calm = (p == 2);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if ($urandom_range(99) < alloc_pct[p]) begin
					offer(OP_ALLOC, {$urandom, $urandom}, 1'b0, '0, ST_OK);
				end else begin
					sel = $urandom_range(99);
					if (sel < 75) begin
						// mostly release a block that is in use, at a random offset
						idx = $urandom_range(NB - 1);
						for (int k = 0; k < NB && !block_used[idx]; k++) idx = (idx + 1) % NB;
						a = base_reg + 64'(idx) * 64'(BB) + 64'($urandom_range(BB - 1));
					end else begin
						case (sel % 6)
							0: a = '0;
							1: a = {$urandom, $urandom};
							2: a = base_reg - 64'($urandom_range(4096, 1));
							3: a = base_reg + SPAN + 64'($urandom_range(100000));
							4: a = base_reg + SPAN - 64'd1;
							default: a = base_reg + SPAN;
						endcase
					end
					offer(OP_FREE, a, 1'b0, '0, ST_OK);
				end
			end
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (errors == 0) begin
			$display("PASS bitmap_block_allocator");
		end else begin
			$display("FAIL bitmap_block_allocator");
		end
		$finish;
	end
endmodule
